// ===== rtl/base64_stream_codec_defines.svh =====
// Assertion macros for the codec RTL
`ifndef BASE64_STREAM_CODEC_DEFINES_SVH
`define BASE64_STREAM_CODEC_DEFINES_SVH

// same-cycle implication, disabled in reset
`define B64_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64 check failed");

// next-cycle implication, disabled in reset
`define B64_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64 check failed");

`endif

// ===== rtl/b64_pkg.sv =====
// Shared types, constants and alphabet functions for the Base64 codec
`default_nettype none
package b64_pkg;

  localparam logic [12:0] LEN_LIMIT_MAX = 13'd4096;
  localparam logic [12:0] COUNT_SAT     = 13'd8191;
  localparam logic [12:0] MAXLEN_RESET  = 13'd128;
  localparam logic [7:0]  PAD_CHAR      = 8'h3D;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_MAXLEN = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR  = 2'd1;
  localparam logic [1:0] ST_AFTER_PAD = 2'd2;
  localparam logic [1:0] ST_TOO_LONG  = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       empty;
    logic       last;
    logic [1:0] status;
  } res_t;

  // results of one item, up to four, first in r[0]
  typedef struct packed {
    res_t [3:0] r;
    logic [2:0] n;
  } batch_t;

  function automatic res_t mk_res(logic [7:0] data, logic empty, logic last,
                                  logic [1:0] status);
    res_t r;
    r.data   = data;
    r.empty  = empty;
    r.last   = last;
    r.status = status;
    return r;
  endfunction

  function automatic logic [7:0] enc_char(logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // {valid, value}; valid low for anything outside the alphabet
  function automatic logic [6:0] dec_char(logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end else begin
      r = 7'd0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/b64_step.sv =====
// Message state and single-pass encode/decode of one item
`default_nettype none
module b64_step (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic                clr,
  input  wire logic                mode,
  input  wire logic [12:0]         max_len,
  input  wire logic [7:0]          item_byte,
  input  wire logic                item_last,
  output b64_pkg::batch_t          batch
);
  import b64_pkg::*;

  logic [11:0] bbuf, bbuf_next;
  logic [3:0]  bcnt, bcnt_next;
  logic [1:0]  phase, phase_next;
  logic        pad, pad_next;
  logic [1:0]  err, err_next;
  logic [12:0] cnt, cnt_next;

  always_comb begin
    logic [12:0] lim;
    logic [12:0] cnt_inc;
    logic [11:0] nb;
    logic [3:0]  tb;
    logic [1:0]  pads;
    logic [6:0]  dv;
    logic [2:0]  n;
    logic        clear;
    batch = '0;
    n = 3'd0;
    clear = 1'b0;
    nb = '0;
    tb = '0;
    pads = '0;
    dv = dec_char(item_byte);
    bbuf_next = bbuf;
    bcnt_next = bcnt;
    phase_next = phase;
    pad_next = pad;
    err_next = err;
    cnt_next = cnt;
    lim = (max_len > LEN_LIMIT_MAX) ? LEN_LIMIT_MAX : max_len;
    cnt_inc = (cnt != COUNT_SAT) ? cnt + 13'd1 : cnt;
    if (err != ST_OK) begin
      if (item_last) begin
        batch.r[0] = mk_res(8'd0, 1'b1, 1'b1, err);
        n = 3'd1;
        clear = 1'b1;
      end
    end else if (cnt_inc > lim) begin
      cnt_next = cnt_inc;
      err_next = ST_TOO_LONG;
      if (item_last) begin
        batch.r[0] = mk_res(8'd0, 1'b1, 1'b1, ST_TOO_LONG);
        n = 3'd1;
        clear = 1'b1;
      end
    end else if (mode == MODE_ENCODE) begin
      cnt_next = cnt_inc;
      nb = {bbuf[3:0], item_byte};
      tb = bcnt + 4'd8;
      for (int k = 0; k < 2; k++) begin
        if (tb >= 4'd6) begin
          tb = tb - 4'd6;
          batch.r[n[1:0]] = mk_res(enc_char(6'(nb >> tb)), 1'b0, 1'b0, ST_OK);
          n = n + 3'd1;
        end
      end
      nb = nb & ~(12'hFFF << tb);
      bbuf_next = nb;
      bcnt_next = tb;
      phase_next = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
      if (item_last) begin
        pads = (phase_next == 2'd1) ? 2'd2 : ((phase_next == 2'd2) ? 2'd1 : 2'd0);
        if (tb != 4'd0) begin
          batch.r[n[1:0]] = mk_res(enc_char(6'(nb << (4'd6 - tb))), 1'b0, 1'b0, ST_OK);
          n = n + 3'd1;
        end
        for (int k = 0; k < 2; k++) begin
          if (2'(k) < pads) begin
            batch.r[n[1:0]] = mk_res(PAD_CHAR, 1'b0, 1'b0, ST_OK);
            n = n + 3'd1;
          end
        end
        batch.r[2'(n - 3'd1)].last = 1'b1;
        clear = 1'b1;
      end
    end else begin
      cnt_next = cnt_inc;
      if (item_byte == PAD_CHAR) begin
        pad_next = 1'b1;
      end else if (!dv[6]) begin
        err_next = ST_BAD_CHAR;
      end else if (pad) begin
        err_next = ST_AFTER_PAD;
      end else begin
        nb = {bbuf[5:0], dv[5:0]};
        tb = bcnt + 4'd6;
        if (tb >= 4'd8) begin
          tb = tb - 4'd8;
          batch.r[0] = mk_res(8'(nb >> tb), 1'b0, 1'b0, ST_OK);
          n = 3'd1;
        end
        bbuf_next = nb & ~(12'hFFF << tb);
        bcnt_next = tb;
      end
      phase_next = phase + 2'd1;
      if (item_last) begin
        clear = 1'b1;
        if (err_next != ST_OK) begin
          batch.r[0] = mk_res(8'd0, 1'b1, 1'b1, err_next);
          n = 3'd1;
        end else if (n != 3'd0) begin
          batch.r[0].last = 1'b1;
        end else begin
          batch.r[0] = mk_res(8'd0, 1'b1, 1'b1, ST_OK);
          n = 3'd1;
        end
      end
    end
    if (clear) begin
      bbuf_next = '0;
      bcnt_next = '0;
      phase_next = '0;
      pad_next = 1'b0;
      err_next = ST_OK;
      cnt_next = '0;
    end
    batch.n = n;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      bbuf <= '0;
      bcnt <= '0;
      phase <= '0;
      pad <= 1'b0;
      err <= ST_OK;
      cnt <= '0;
    end else if (step) begin
      bbuf <= bbuf_next;
      bcnt <= bcnt_next;
      phase <= phase_next;
      pad <= pad_next;
      err <= err_next;
      cnt <= cnt_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/b64_outq.sv =====
// Result register bank: holds one item's results and drains one per cycle while out_ready is high
`default_nettype none
module b64_outq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire b64_pkg::batch_t batch,
  output logic                 free,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_empty,
  output logic                 out_last,
  output logic [1:0]           out_status
);
  import b64_pkg::*;
`include "base64_stream_codec_defines.svh"

  res_t [3:0] q;
  logic [1:0] head;
  logic [2:0] count;
  logic       fire;

  assign out_valid  = (count != 3'd0);
  assign fire       = out_valid && out_ready;
  assign free       = (count == 3'd0) || (count == 3'd1 && out_ready);
  assign out_byte   = q[head].data;
  assign out_empty  = q[head].empty;
  assign out_last   = q[head].last;
  assign out_status = q[head].status;

  always_ff @(posedge clk) begin
    if (load) begin
      q <= batch.r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
    end else if (load) begin
      head <= '0;
      count <= batch.n;
    end else if (fire) begin
      head <= head + 2'd1;
      count <= count - 3'd1;
    end
  end

  // the message end is always the final entry of a batch
  `B64_ASSERT_NOW(a_last_is_tail, clk, rst, out_valid && out_last, count == 3'd1)
  // empty results only close a message
  `B64_ASSERT_NOW(a_empty_is_last, clk, rst, out_valid && out_empty, out_last)
  `B64_ASSERT_NOW(a_status_on_empty, clk, rst, out_valid && out_status != ST_OK, out_empty)
  `B64_ASSERT_NEXT(a_load_restarts, clk, rst, load && batch.n != 3'd0, head == 2'd0)
  `B64_ASSERT_NOW(a_load_when_free, clk, rst, load, count == 3'd0 || fire)

endmodule
`default_nettype wire

// ===== rtl/base64_stream_codec.sv =====
// Path: an accepted item is held in the input register until the result bank is free, then
// b64_step processes it and its results are registered in the result bank and presented from it.
// Throughput: one item per cycle while out_ready is high and the item yields at most one result;
// otherwise the single-result output port drains the result bank (up to 4 results) one at a time.
// Reset (rst, synchronous, active high): encode mode, length limit 128, message state
// cleared, no results pending. Writing the mode register also clears message state.
`default_nettype none
module base64_stream_codec (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_empty,
  output logic             out_last,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);
  import b64_pkg::*;

  logic        mode;
  logic [12:0] max_len;
  logic        ir_valid;
  logic [7:0]  ir_byte;
  logic        ir_last;
  logic        step;
  logic        free;
  logic        cfg_fire;
  logic        mode_wr;
  batch_t      batch;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign mode_wr   = cfg_fire && (cfg_index == CFG_MODE);
  assign step      = ir_valid && free;
  assign in_ready  = !ir_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
      max_len <= MAXLEN_RESET;
    end else if (cfg_fire) begin
      case (cfg_index)
        CFG_MODE:   mode <= cfg_data[0];
        CFG_MAXLEN: max_len <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ir_valid <= 1'b1;
    end else if (step) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ir_byte <= in_byte;
      ir_last <= in_last;
    end
  end

  b64_step u_step (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .clr       (mode_wr),
    .mode      (mode),
    .max_len   (max_len),
    .item_byte (ir_byte),
    .item_last (ir_last),
    .batch     (batch)
  );

  b64_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .batch      (batch),
    .free       (free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_empty  (out_empty),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule
`default_nettype wire
